FILE: design/cimpf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimpf_pkg
// Shared types, constants and functions of the case-insensitive phrase filter.
// ----------------------------------------------------------------------------
package cimpf_pkg;

   localparam int PATTERNS_DEFAULT = 16;
   localparam int PAT_LEN_DEFAULT  = 32;

   localparam logic [1:0] STATUS_OK     = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_FULL   = 2'd2;

   localparam logic REG_PROMPT_LIMIT = 1'b0;
   localparam logic REG_OUT_CAPACITY = 1'b1;

   localparam logic [15:0] LIMIT_RESET = 16'd4096;
   localparam logic [15:0] COUNT_MAX   = 16'hFFFF;

   localparam logic [7:0] UPPER_A   = 8'h41;
   localparam logic [7:0] UPPER_Z   = 8'h5A;
   localparam logic [7:0] CASE_STEP = 8'd32;

   localparam int DEFAULT_COUNT  = 8;
   localparam int DEFAULT_TEXT_W = 8 * 28;

   localparam logic [DEFAULT_TEXT_W-1:0] DEFAULT_TEXT [DEFAULT_COUNT] = '{
      "ignore previous instructions",
      "ignore all prior",
      "disregard above",
      "system prompt:",
      "you are now",
      "new instructions:",
      "override:",
      "forget everything"
   };

   localparam int DEFAULT_LEN [DEFAULT_COUNT] = '{28, 16, 15, 14, 11, 17, 9, 17};

   typedef struct packed {
      logic shift_en;
      logic len_wr;
   } slot_ctl_type;

   function automatic logic [7:0] fold(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= UPPER_A && c <= UPPER_Z) begin
         r = c + CASE_STEP;
      end
      return r;
   endfunction

   // entry j counts back from the last stored character
   function automatic logic [7:0] default_char(input int slot, input int j, input int win);
      int full;
      int kept;
      logic [7:0] c;
      c = '0;
      if (slot < DEFAULT_COUNT) begin
         full = DEFAULT_LEN[slot];
         kept = (full < win) ? full : win;
         if (j < kept) begin
            c = fold(DEFAULT_TEXT[slot][8*(j+full-kept) +: 8]);
         end
      end
      return c;
   endfunction

   function automatic int default_len(input int slot, input int win);
      int r;
      r = 0;
      if (slot < DEFAULT_COUNT) begin
         r = (DEFAULT_LEN[slot] < win) ? DEFAULT_LEN[slot] : win;
      end
      return r;
   endfunction

endpackage

FILE: design/cimpf_window_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimpf_window_cell
// One byte of the recent-prompt window; shifts toward the older neighbor.
// ----------------------------------------------------------------------------
module cimpf_window_cell (
   input  logic       clock,
   input  logic       reset,
   input  logic       shift_en,
   input  logic       clear,
   input  logic [7:0] d_in,
   output logic [7:0] q_out
);

   logic [7:0] byte_ff;
   logic [7:0] byte_in;

   always_comb begin
      byte_in = byte_ff;
      if (clear) begin
         byte_in = '0;
      end else if (shift_en) begin
         byte_in = d_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         byte_ff <= '0;
      end else begin
         byte_ff <= byte_in;
      end
   end

   assign q_out = byte_ff;

endmodule

FILE: design/cimpf_slot_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cimpf_slot_cell
// One phrase slot: stores its phrase newest-first and compares it against
// the prompt window on every byte.
// ----------------------------------------------------------------------------
module cimpf_slot_cell #(
   parameter int SLOT = 0,
   parameter int WIN  = cimpf_pkg::PAT_LEN_DEFAULT - 1,
   parameter int LEN_W = $clog2(WIN + 1)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cimpf_pkg::slot_ctl_type  ctl,
   input  logic [7:0]               char_in,
   input  logic [LEN_W-1:0]         len_in,
   input  logic [WIN-1:0][7:0]      window,
   output logic                     match
);

   logic [WIN-1:0][7:0] chars_ff;
   logic [WIN-1:0][7:0] chars_in;
   logic [LEN_W-1:0]    len_ff;
   logic [LEN_W-1:0]    len_in_next;
   logic [WIN-1:0]      equal;

   always_comb begin
      chars_in = chars_ff;
      if (ctl.shift_en) begin
         chars_in[0] = char_in;
         for (int j = 1; j < WIN; j++) begin
            chars_in[j] = chars_ff[j-1];
         end
      end
      len_in_next = ctl.len_wr ? len_in : len_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < WIN; j++) begin
            chars_ff[j] <= cimpf_pkg::default_char(SLOT, j, WIN);
         end
         len_ff <= LEN_W'(cimpf_pkg::default_len(SLOT, WIN));
      end else begin
         chars_ff <= chars_in;
         len_ff   <= len_in_next;
      end
   end

   always_comb begin
      for (int j = 0; j < WIN; j++) begin
         equal[j] = (LEN_W'(j) >= len_ff) || (chars_ff[j] == window[j]);
      end
      match = (len_ff != '0) && (&equal);
   end

endmodule

FILE: design/case_insensitive_multi_pattern_filter_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_insensitive_multi_pattern_filter_top
// Screens a byte-streamed prompt against a table of case-folded phrases.
// ----------------------------------------------------------------------------
// Usage:
//   req_ carries one byte per transaction: tdata is the byte, tlast closes a
//   phrase or prompt, tuser selects phrase append (0) or prompt byte (1).
//   Every request transaction yields exactly one rsp_ transaction; rsp_tlast
//   marks the verdict that closes a prompt.
//   A byte is taken every cycle while req_tready is high; its response is
//   loaded into the output register. The window of recent bytes is a shift
//   chain of cells; every phrase slot cell compares against it as a byte is
//   taken. req_tready drops only while the output register holds an untaken
//   response and rsp_tready is low; the stream then holds without loss.
//   csr_ is an APB-style port: the prompt length limit at 0x0, out_capacity
//   at 0x4, both 4096 after reset. Reset loads the eight built-in phrases,
//   clears the window, the prompt length, the hit and the violation count.
// ----------------------------------------------------------------------------
module case_insensitive_multi_pattern_filter_top #(
   parameter int PATTERNS = cimpf_pkg::PATTERNS_DEFAULT,
   parameter int PAT_LEN  = cimpf_pkg::PAT_LEN_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] byte_value
   input  logic        req_tlast,
   input  logic        req_tuser,   // [0] mode
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // [1:0] status, [5:2] match_slot,
                                    // [21:6] kept_length, [22] was_truncated,
                                    // [38:23] violation_total, [39] zero
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   localparam int WIN        = PAT_LEN - 1;
   localparam int LEN_W      = $clog2(WIN + 1);
   localparam int CNT_W      = $clog2(PATTERNS + 1);
   localparam int SLOT_W     = $clog2(PATTERNS);
   localparam int SLOT_EXT_W = (SLOT_W > 4) ? SLOT_W : 4;

   logic [15:0] max_len_ff, max_len_in;
   logic [15:0] capacity_ff, capacity_in;

   logic [CNT_W-1:0]  count_ff, count_in;
   logic [LEN_W-1:0]  pos_ff, pos_in;
   logic [15:0]       plen_ff, plen_in;
   logic              hit_ff, hit_in;
   logic [SLOT_W-1:0] hit_slot_ff, hit_slot_in;
   logic [15:0]       viol_ff, viol_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [39:0] rsp_data_ff, rsp_data_in;
   logic        rsp_last_ff, rsp_last_in;

   logic                  accept;
   logic                  prompt_take;
   logic                  phrase_take;
   logic [7:0]            folded;
   logic [WIN-1:0][7:0]   win_q;
   logic [WIN-1:0][7:0]   win_d;
   logic [PATTERNS-1:0]   match;
   cimpf_pkg::slot_ctl_type slot_ctl [PATTERNS];
   logic                  table_full;
   logic                  store_byte;
   logic [LEN_W-1:0]      pos_next;
   logic                  close_phrase;
   logic                  cand_valid;
   logic [SLOT_W-1:0]     cand_slot;
   logic [15:0]           limit;
   logic [15:0]           cap;
   logic [15:0]           kept;
   logic                  trunc;
   logic [SLOT_EXT_W-1:0] slot_ext;
   logic [1:0]            status;
   logic [SLOT_W-1:0]     verdict_slot;

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept      = req_tvalid && req_tready;
   assign prompt_take = accept && req_tuser;
   assign phrase_take = accept && !req_tuser;
   assign folded      = cimpf_pkg::fold(req_tdata);

   // configuration port
   assign csr_pready = 1'b1;

   always_comb begin
      max_len_in  = max_len_ff;
      capacity_in = capacity_ff;
      if (csr_psel && csr_penable && csr_pwrite) begin
         if (csr_paddr[2] == cimpf_pkg::REG_PROMPT_LIMIT) begin
            max_len_in = csr_pwdata[15:0];
         end else begin
            capacity_in = csr_pwdata[15:0];
         end
      end
      if (csr_paddr[2] == cimpf_pkg::REG_OUT_CAPACITY) begin
         csr_prdata = {16'd0, capacity_ff};
      end else begin
         csr_prdata = {16'd0, max_len_ff};
      end
   end

   // prompt window chain
   genvar gj;
   generate
      for (gj = 0; gj < WIN; gj++) begin : g_win
         if (gj == 0) begin : g_head
            assign win_d[gj] = folded;
         end else begin : g_tail
            assign win_d[gj] = win_q[gj-1];
         end
         cimpf_window_cell u_cell (
            .clock    (clock),
            .reset    (reset),
            .shift_en (prompt_take),
            .clear    (prompt_take && req_tlast),
            .d_in     (win_d[gj]),
            .q_out    (win_q[gj])
         );
      end
   endgenerate

   // phrase append control
   assign table_full   = (count_ff >= CNT_W'(PATTERNS));
   assign store_byte   = !table_full && (req_tdata != 8'd0) && (pos_ff < LEN_W'(WIN));
   assign pos_next     = store_byte ? pos_ff + LEN_W'(1) : pos_ff;
   assign close_phrase = !table_full && req_tlast && (pos_next != '0);

   genvar gs;
   generate
      for (gs = 0; gs < PATTERNS; gs++) begin : g_slot
         assign slot_ctl[gs].shift_en = phrase_take && store_byte
                                        && (count_ff == CNT_W'(gs));
         assign slot_ctl[gs].len_wr   = phrase_take && close_phrase
                                        && (count_ff == CNT_W'(gs));
         cimpf_slot_cell #(
            .SLOT  (gs),
            .WIN   (WIN),
            .LEN_W (LEN_W)
         ) u_slot (
            .clock   (clock),
            .reset   (reset),
            .ctl     (slot_ctl[gs]),
            .char_in (folded),
            .len_in  (pos_next),
            .window  (win_d),
            .match   (match[gs])
         );
      end
   endgenerate

   // lowest matching slot
   always_comb begin
      cand_valid = 1'b0;
      cand_slot  = '0;
      for (int s = PATTERNS - 1; s >= 0; s--) begin
         if (match[s]) begin
            cand_valid = 1'b1;
            cand_slot  = SLOT_W'(s);
         end
      end
   end

   always_comb begin
      count_in     = count_ff;
      pos_in       = pos_ff;
      plen_in      = plen_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      viol_in      = viol_ff;
      status       = cimpf_pkg::STATUS_OK;
      kept         = '0;
      trunc        = 1'b0;
      verdict_slot = '0;
      limit        = (max_len_ff == '0) ? 16'd1 : max_len_ff;
      cap          = (capacity_ff == '0) ? 16'd1 : capacity_ff;

      if (phrase_take) begin
         if (table_full) begin
            status = cimpf_pkg::STATUS_FULL;
         end else begin
            pos_in = pos_next;
            if (req_tlast) begin
               pos_in = '0;
               if (close_phrase) begin
                  count_in = count_ff + CNT_W'(1);
               end
            end
         end
      end

      if (prompt_take) begin
         plen_in = (plen_ff == cimpf_pkg::COUNT_MAX) ? plen_ff : plen_ff + 16'd1;
         if (cand_valid && (!hit_ff || cand_slot < hit_slot_ff)) begin
            hit_in      = 1'b1;
            hit_slot_in = cand_slot;
         end
         if (req_tlast) begin
            if (hit_in) begin
               status       = cimpf_pkg::STATUS_REJECT;
               verdict_slot = hit_slot_in;
               if (viol_ff != cimpf_pkg::COUNT_MAX) begin
                  viol_in = viol_ff + 16'd1;
               end
            end else begin
               kept = plen_in;
               if (kept >= limit) begin
                  trunc = 1'b1;
                  kept  = limit - 16'd1;
               end
               if (kept > cap - 16'd1) begin
                  kept = cap - 16'd1;
               end
            end
            plen_in     = '0;
            hit_in      = 1'b0;
            hit_slot_in = '0;
         end
      end
   end

   // output register
   always_comb begin
      slot_ext     = SLOT_EXT_W'(verdict_slot);
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, viol_in, trunc, kept, slot_ext[3:0], status};
         rsp_last_in  = prompt_take && req_tlast;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff   <= cimpf_pkg::LIMIT_RESET;
         capacity_ff  <= cimpf_pkg::LIMIT_RESET;
         count_ff     <= CNT_W'(cimpf_pkg::DEFAULT_COUNT);
         pos_ff       <= '0;
         plen_ff      <= '0;
         hit_ff       <= 1'b0;
         hit_slot_ff  <= '0;
         viol_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         rsp_last_ff  <= 1'b0;
      end else begin
         max_len_ff   <= max_len_in;
         capacity_ff  <= capacity_in;
         count_ff     <= count_in;
         pos_ff       <= pos_in;
         plen_ff      <= plen_in;
         hit_ff       <= hit_in;
         hit_slot_ff  <= hit_slot_in;
         viol_ff      <= viol_in;
         rsp_valid_ff <= rsp_valid_in;
         rsp_last_ff  <= rsp_last_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: verif/case_insensitive_multi_pattern_filter_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// case_insensitive_multi_pattern_filter_top_test
// Streams phrase and prompt bytes into the filter and checks every response
// against a behavioral copy of the phrase table, the folded byte window, the
// prompt length and the violation count, or against fixed results given in a
// short directed table that comes first. Random phases follow, each under its
// own length limit and buffer size. They are mostly prompts built around
// table phrases in mixed case, with phrase appends, noise and broken phrases
// mixed in. The last phase runs without idling on either side.
// ----------------------------------------------------------------------------
module case_insensitive_multi_pattern_filter_top_test;

   localparam int SLOTS     = 16;
   localparam int WINDOW    = 31;
   localparam int QUIET_MAX = 1000;
   localparam int PHASES    = 8;
   localparam int PHASE_ITEMS = 225;

   localparam bit MODE_PHRASE = 1'b0;
   localparam bit MODE_PROMPT = 1'b1;

   localparam logic [1:0] ST_OK     = cimpf_pkg::STATUS_OK;
   localparam logic [1:0] ST_REJECT = cimpf_pkg::STATUS_REJECT;

   localparam logic [2:0] ADDR_MAX_LEN  = {cimpf_pkg::REG_PROMPT_LIMIT, 2'b00};
   localparam logic [2:0] ADDR_CAPACITY = {cimpf_pkg::REG_OUT_CAPACITY, 2'b00};

   typedef struct packed {
      logic [1:0]  status;
      logic        verdict;
      logic [3:0]  slot;
      logic [15:0] kept;
      logic        truncated;
      logic [15:0] violations;
   } screen_result_type;

   typedef struct packed {
      logic              mode;
      logic [7:0]        data;
      logic              last;
      logic              typed;
      screen_result_type result;
   } screen_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = '0;
   logic        req_tlast = 1'b0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic        rsp_tlast;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   case_insensitive_multi_pattern_filter_top dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tlast   (req_tlast),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // filter image
   logic [7:0]  phrase_tbl [SLOTS][WINDOW];
   int unsigned phrase_len [SLOTS];
   int unsigned phrase_cnt;
   int unsigned append_pos;
   logic [7:0]  window_bytes [WINDOW];
   int unsigned prompt_len;
   bit          hit_seen;
   int unsigned hit_slot;
   int unsigned violations;
   int unsigned limit_reg;
   int unsigned capacity_reg;

   screen_result_type pending_results [$];
   int  fail_count = 0;
   int  item_count = 0;
   int  quiet_cycles = 0;
   bit  idle_en = 1'b0;
   int  stall_left = 0;

   string default_text [8] = '{
      "ignore previous instructions", "ignore all prior", "disregard above",
      "system prompt:", "you are now", "new instructions:", "override:",
      "forget everything"
   };

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
   endfunction

   function automatic void clear_window();
      foreach (window_bytes[i]) window_bytes[i] = '0;
      prompt_len = 0;
      hit_seen = 1'b0;
      hit_slot = 0;
   endfunction

   function automatic void load_filter_image();
      int unsigned k;
      foreach (phrase_tbl[s, j]) phrase_tbl[s][j] = '0;
      foreach (phrase_len[s]) phrase_len[s] = 0;
      for (int s = 0; s < 8; s++) begin
         for (k = 0; k < default_text[s].len() && k < WINDOW; k++) begin
            phrase_tbl[s][k] = to_lower(default_text[s].getc(k));
         end
         phrase_len[s] = k;
      end
      phrase_cnt = 8;
      append_pos = 0;
      violations = 0;
      limit_reg = cimpf_pkg::LIMIT_RESET;
      capacity_reg = cimpf_pkg::LIMIT_RESET;
      clear_window();
   endfunction

   function automatic screen_result_type screen_byte(input logic mode, input logic [7:0] data,
                                                     input logic last);
      screen_result_type r;
      int unsigned len, n, lim, cap;
      bit same;
      r = '0;
      if (mode == MODE_PHRASE) begin
         if (phrase_cnt >= SLOTS) begin
            r.status = cimpf_pkg::STATUS_FULL;
         end else begin
            if (data != 0 && append_pos < WINDOW) begin
               phrase_tbl[phrase_cnt][append_pos] = to_lower(data);
               append_pos++;
            end
            if (last) begin
               if (append_pos > 0) begin
                  phrase_len[phrase_cnt] = append_pos;
                  phrase_cnt++;
               end
               append_pos = 0;
            end
         end
      end else begin
         for (int i = WINDOW - 1; i > 0; i--) window_bytes[i] = window_bytes[i-1];
         window_bytes[0] = to_lower(data);
         if (prompt_len < cimpf_pkg::COUNT_MAX) prompt_len++;
         for (int unsigned s = 0; s < phrase_cnt && s < SLOTS; s++) begin
            len = phrase_len[s];
            if (len == 0 || len > WINDOW || len > prompt_len) continue;
            if (hit_seen && hit_slot <= s) break;
            same = 1'b1;
            for (int unsigned k = 0; k < len; k++) begin
               if (phrase_tbl[s][k] != window_bytes[len-1-k]) same = 1'b0;
            end
            if (same) begin
               hit_seen = 1'b1;
               hit_slot = s;
               break;
            end
         end
         if (last) begin
            r.verdict = 1'b1;
            if (hit_seen) begin
               r.status = cimpf_pkg::STATUS_REJECT;
               r.slot = hit_slot[3:0];
               if (violations < cimpf_pkg::COUNT_MAX) violations++;
            end else begin
               lim = (limit_reg == 0) ? 1 : limit_reg;
               cap = (capacity_reg == 0) ? 1 : capacity_reg;
               n = prompt_len;
               if (n >= lim) begin
                  r.truncated = 1'b1;
                  n = lim - 1;
               end
               if (n > cap - 1) n = cap - 1;
               r.kept = n[15:0];
            end
            clear_window();
         end
      end
      r.violations = violations[15:0];
      return r;
   endfunction

   task automatic send_byte(input logic mode, input logic [7:0] data, input logic last,
                            input logic typed = 1'b0, input screen_result_type given = '0);
      screen_result_type predicted;
      @(negedge clock);
      if (idle_en && $urandom_range(0, 7) == 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, 3)) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser = mode;
      req_tdata = data;
      req_tlast = last;
      do @(posedge clock); while (!req_tready);
      predicted = screen_byte(mode, data, last);
      pending_results.push_back(typed ? given : predicted);
      item_count++;
   endtask

   task automatic drain_stream();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] addr, input logic [15:0] value);
      @(negedge clock);
      csr_psel = 1'b1;
      csr_pwrite = 1'b1;
      csr_paddr = addr;
      csr_pwdata = {16'd0, value};
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (addr == ADDR_MAX_LEN) limit_reg = value;
      else capacity_reg = value;
      @(negedge clock);
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
   endtask

   function automatic logic [7:0] text_byte();
      logic [7:0] c;
      if ($urandom_range(0, 9) < 6) begin
         c = "a" + 8'($urandom_range(0, 25));
         if ($urandom_range(0, 1)) c = c - 8'd32;
      end else begin
         c = 8'($urandom_range(0, 255));
      end
      return c;
   endfunction

   task automatic send_phrase();
      int unsigned len;
      logic [7:0] c;
      case ($urandom_range(0, 9))
         0: len = 0;
         1: len = $urandom_range(32, 40);
         default: len = $urandom_range(1, 6);
      endcase
      if (len == 0) begin
         send_byte(MODE_PHRASE, 8'h00, 1'b1);
      end else begin
         for (int unsigned k = 0; k < len; k++) begin
            c = ($urandom_range(0, 9) == 0) ? 8'h00 : text_byte();
            send_byte(MODE_PHRASE, c, k == len - 1);
         end
      end
   endtask

   task automatic send_prompt(input bit noisy);
      logic [7:0] body [$];
      logic [7:0] c;
      int unsigned s, len;
      body = {};
      if (noisy) begin
         repeat ($urandom_range(1, 60)) body.push_back(8'($urandom_range(0, 255)));
      end else begin
         repeat ($urandom_range(0, 8)) body.push_back(text_byte());
         if ($urandom_range(0, 9) < 6) begin
            s = $urandom_range(0, phrase_cnt - 1);
            len = phrase_len[s];
            // broken phrase: leave off its last character
            if ($urandom_range(0, 4) == 0) len--;
            for (int unsigned k = 0; k < len; k++) begin
               c = phrase_tbl[s][k];
               if (c >= "a" && c <= "z" && $urandom_range(0, 1)) c = c - 8'd32;
               body.push_back(c);
            end
         end
         if ($urandom_range(0, 9) == 0) begin
            repeat ($urandom_range(20, 80)) body.push_back(text_byte());
         end else begin
            repeat ($urandom_range(0, 8)) body.push_back(text_byte());
         end
         if (body.size() == 0) body.push_back(text_byte());
      end
      foreach (body[i]) send_byte(MODE_PROMPT, body[i], i == body.size() - 1);
   endtask

   screen_row_type directed_rows [23] = '{
      '{MODE_PROMPT, 8'h00, 1'b1, 1'b1, '{ST_OK, 1'b1, 4'd0, 16'd1, 1'b0, 16'd0}},
      '{MODE_PROMPT, 8'hFF, 1'b0, 1'b1, '{ST_OK, 1'b0, 4'd0, 16'd0, 1'b0, 16'd0}},
      '{MODE_PROMPT, "X",   1'b1, 1'b1, '{ST_OK, 1'b1, 4'd0, 16'd2, 1'b0, 16'd0}},
      '{MODE_PROMPT, "O",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "V",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "E",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "R",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "R",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "I",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "D",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "E",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, ":",   1'b1, 1'b1, '{ST_REJECT, 1'b1, 4'd6, 16'd0, 1'b0, 16'd1}},
      '{MODE_PHRASE, 8'h00, 1'b1, 1'b1, '{ST_OK, 1'b0, 4'd0, 16'd0, 1'b0, 16'd1}},
      '{MODE_PHRASE, "A",   1'b0, 1'b0, '0},
      '{MODE_PHRASE, "b",   1'b1, 1'b1, '{ST_OK, 1'b0, 4'd0, 16'd0, 1'b0, 16'd1}},
      '{MODE_PROMPT, "a",   1'b0, 1'b0, '0},
      '{MODE_PROMPT, "B",   1'b1, 1'b1, '{ST_REJECT, 1'b1, 4'd8, 16'd0, 1'b0, 16'd2}},
      '{MODE_PROMPT, "z",   1'b0, 1'b0, '0},
      '{MODE_PHRASE, "Z",   1'b0, 1'b0, '0},
      '{MODE_PHRASE, "q",   1'b1, 1'b0, '0},
      '{MODE_PROMPT, "Q",   1'b1, 1'b1, '{ST_REJECT, 1'b1, 4'd9, 16'd0, 1'b0, 16'd3}},
      '{MODE_PHRASE, 8'hFF, 1'b1, 1'b1, '{ST_OK, 1'b0, 4'd0, 16'd0, 1'b0, 16'd3}},
      '{MODE_PROMPT, 8'hFF, 1'b1, 1'b1, '{ST_REJECT, 1'b1, 4'd10, 16'd0, 1'b0, 16'd4}}
   };

   initial begin
      logic [15:0] limit_set [PHASES];
      logic [15:0] capacity_set [PHASES];
      int phase_end;
      int pick;
      limit_set = '{cimpf_pkg::LIMIT_RESET, 16'd1, 16'd0, cimpf_pkg::COUNT_MAX,
                    16'd5, 16'd20, 16'd0, 16'd0};
      capacity_set = '{cimpf_pkg::LIMIT_RESET, 16'd1, 16'd0, cimpf_pkg::COUNT_MAX,
                       16'd20, 16'd5, 16'd0, 16'd0};
      limit_set[6] = 16'($urandom_range(2, 40));
      capacity_set[6] = 16'($urandom_range(2, 40));
      limit_set[7] = 16'($urandom_range(0, 65535));
      capacity_set[7] = 16'($urandom_range(0, 65535));
      load_filter_image();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      idle_en = 1'b1;
      foreach (directed_rows[i]) begin
         send_byte(directed_rows[i].mode, directed_rows[i].data, directed_rows[i].last,
                   directed_rows[i].typed, directed_rows[i].result);
      end

      for (int p = 0; p < PHASES; p++) begin
         if (p != 0) begin
            drain_stream();
            csr_write(ADDR_MAX_LEN, limit_set[p]);
            csr_write(ADDR_CAPACITY, capacity_set[p]);
         end
         idle_en = (p < PHASES - 1) && ($urandom_range(0, 3) != 0);
         phase_end = item_count + PHASE_ITEMS;
         while (item_count < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
               send_phrase();
            end else if (pick < 12) begin
               send_prompt(1'b1);
            end else begin
               send_prompt(1'b0);
            end
         end
      end

      drain_stream();
      if (fail_count == 0) begin
         $display("case_insensitive_multi_pattern_filter_top_test passed");
      end else begin
         $display("case_insensitive_multi_pattern_filter_top_test failed");
      end
      $finish;
   end

   always @(negedge clock) begin
      if (stall_left > 0) begin
         rsp_tready = 1'b0;
         stall_left--;
      end else if (idle_en && $urandom_range(0, 9) == 0) begin
         rsp_tready = 1'b0;
         stall_left = $urandom_range(0, 2);
      end else begin
         rsp_tready = 1'b1;
      end
   end

   always @(posedge clock) begin
      screen_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            $error("rsp transaction with no expected result");
            fail_count++;
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $error("status: expected %0d, actual %0d", want.status, rsp_tdata[1:0]);
               fail_count++;
            end
            if (rsp_tlast !== want.verdict) begin
               $error("verdict_valid: expected %0d, actual %0d", want.verdict, rsp_tlast);
               fail_count++;
            end
            if (rsp_tdata[5:2] !== want.slot) begin
               $error("match_slot: expected %0d, actual %0d", want.slot, rsp_tdata[5:2]);
               fail_count++;
            end
            if (rsp_tdata[21:6] !== want.kept) begin
               $error("kept_length: expected %0d, actual %0d", want.kept, rsp_tdata[21:6]);
               fail_count++;
            end
            if (rsp_tdata[22] !== want.truncated) begin
               $error("was_truncated: expected %0d, actual %0d", want.truncated,
                      rsp_tdata[22]);
               fail_count++;
            end
            if (rsp_tdata[38:23] !== want.violations) begin
               $error("violation_total: expected %0d, actual %0d", want.violations,
                      rsp_tdata[38:23]);
               fail_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_MAX) begin
         $display("case_insensitive_multi_pattern_filter_top_test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule
